### src/bpp_pkg.sv
// ----------------------------------------------------------------------------
// Barberpole phaser package
// Sizes, widths, register indexes and the history write bundle shared by the
// phaser top level and its history store.
// ----------------------------------------------------------------------------
package bpp_pkg;

   localparam int PATHS      = 4;
   localparam int MAX_STAGES = 12;

   localparam int HIST_DEPTH = PATHS * MAX_STAGES;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int PATH_W     = (PATHS > 1) ? $clog2(PATHS) : 1;
   localparam int STG_W      = $clog2(MAX_STAGES + 1);

   localparam int SAMPLE_W = 24;
   localparam int STATE_W  = 32;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 19;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + $clog2(PATHS) + 1;

   localparam logic [15:0] ONE_Q15 = 16'd32768;
   localparam logic [31:0] PHASE_STEP = 32'(64'h1_0000_0000 / PATHS);

   typedef enum logic [2:0] {
      CSR_BYPASS     = 3'd0,
      CSR_PHASE_INC  = 3'd1,
      CSR_SWEEP_TOP  = 3'd2,
      CSR_SWEEP_BTM  = 3'd3,
      CSR_FEEDBACK   = 3'd4,
      CSR_WET_MIX    = 3'd5,
      CSR_STAGES     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                      en;
      logic [ADDR_W-1:0]         addr;
      logic signed [STATE_W-1:0] in_val;
      logic signed [STATE_W-1:0] out_val;
   } bpp_hist_wr_type;

endpackage

### src/barberpole_phaser.sv
// ----------------------------------------------------------------------------
// Barberpole phaser
// Sequence: per sample a dry scaling step, then for each path square, coefficient,
//   feedback and signal steps, a multiply and write-back pair per allpass stage
//   and three mix steps, then accumulate and output; bypass goes from the dry step
//   straight to output. The single shared multiplier serves every step and each
//   allpass stage waits on the last; a new sample is taken once the last is handed off.
// Reset: synchronous; registers return to defaults, LFO phase and feedback
//   clear at once, history reads as zero through valid bits.
// ----------------------------------------------------------------------------
module barberpole_phaser
   import bpp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_DRY, S_SQ, S_COEF, S_FB, S_SIG, S_ST_MUL, S_ST_WB,
      S_MIX1, S_MIX2, S_MIX3, S_ACC, S_OUT
   } state_type;

   state_type                  state_ff;
   logic                       bypass_ff;
   logic [31:0]                phase_inc_ff;
   logic [15:0]                sweep_top_ff;
   logic [15:0]                sweep_btm_ff;
   logic [14:0]                feedback_ff;
   logic [15:0]                wet_mix_ff;
   logic [3:0]                 stages_ff;

   logic [31:0]                lfo_phase_ff;
   logic [31:0]                ph_ff;
   logic [PATH_W-1:0]          p_ff;
   logic [STG_W-1:0]           k_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [STATE_W-1:0]  dry_ff;
   logic signed [STATE_W-1:0]  sig_ff;
   logic [15:0]                coef_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   tmp_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [STATE_W-1:0]  fb_ff [PATHS];
   logic signed [SAMPLE_W-1:0] out_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_out_ff;

   logic [15:0]                top_cap;
   logic [15:0]                btm_cap;
   logic [15:0]                lo;
   logic [15:0]                diff;
   logic [15:0]                wet_cap;
   logic [STG_W-1:0]           nst;
   logic [15:0]                m;
   logic [16:0]                gain;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [63:0]         prod_ext;
   logic signed [63:0]         dry_full;
   logic signed [63:0]         mix_round;
   logic signed [63:0]         y_full;
   logic signed [63:0]         sig_full;
   logic signed [63:0]         acc_next;
   logic signed [63:0]         out_full;
   logic signed [STATE_W-1:0]  rd_in_hist;
   logic signed [STATE_W-1:0]  rd_out_hist;
   logic                       rd_en;
   logic [STG_W-1:0]           rd_k;
   logic [ADDR_W-1:0]          rd_addr;
   bpp_hist_wr_type            hist_wr;

   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [STATE_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lw;
      hi = 64'sd2147483647;
      lw = -64'sd2147483648;
      if (v > hi) begin
         return 32'sh7fff_ffff;
      end else if (v < lw) begin
         return 32'sh8000_0000;
      end
      return v[STATE_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lw;
      hi = 64'sd8388607;
      lw = -64'sd8388608;
      if (v > hi) begin
         return 24'sh7f_ffff;
      end else if (v < lw) begin
         return 24'sh80_0000;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   // ---- configuration derived values ----
   always_comb begin
      top_cap = (sweep_top_ff > ONE_Q15) ? ONE_Q15 : sweep_top_ff;
      btm_cap = (sweep_btm_ff > ONE_Q15) ? ONE_Q15 : sweep_btm_ff;
      wet_cap = (wet_mix_ff > ONE_Q15) ? ONE_Q15 : wet_mix_ff;
      lo      = (top_cap < btm_cap) ? top_cap : btm_cap;
      diff    = (top_cap < btm_cap) ? (btm_cap - top_cap) : (top_cap - btm_cap);
      nst     = STG_W'(((int'(stages_ff) > MAX_STAGES) ? MAX_STAGES : int'(stages_ff))
                       & ~1);
      m       = ~ph_ff[31:16];
      gain    = ({1'b0, m} <= 17'd32768) ? {1'b0, m} : (17'd65536 - {1'b0, m});
   end

   // ---- shared multiplier operand select ----
   assign prod_ext  = 64'(prod_ff);
   assign dry_full  = round_shift(prod_ext, 17);
   assign mix_round = round_shift(64'(tmp_ff) + prod_ext, 15);
   assign y_full    = round_shift(prod_ext, 15) - 64'(rd_in_hist);
   assign sig_full  = 64'(dry_ff) + round_shift(prod_ext, 15);
   assign acc_next  = 64'(acc_ff) + prod_ext;
   assign out_full  = round_shift(acc_next, 21);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_DRY: begin
            mul_a = {{5{x_ff[SAMPLE_W-1]}}, x_ff, 5'b0};
            mul_b = 19'sd131072 - MUL_B_W'(feedback_ff);
         end
         S_SQ: begin
            mul_a = MUL_A_W'(m);
            mul_b = MUL_B_W'(m);
         end
         S_COEF: begin
            mul_a = MUL_A_W'(prod_ff[31:17]);
            mul_b = MUL_B_W'(diff);
         end
         S_FB: begin
            mul_a = MUL_A_W'(fb_ff[p_ff]);
            mul_b = MUL_B_W'(feedback_ff);
         end
         S_ST_MUL: begin
            mul_a = MUL_A_W'(rd_out_hist) + MUL_A_W'(sig_ff);
            mul_b = MUL_B_W'(coef_ff);
         end
         S_MIX1: begin
            mul_a = MUL_A_W'(dry_ff);
            mul_b = MUL_B_W'(ONE_Q15 - wet_cap);
         end
         S_MIX2: begin
            mul_a = MUL_A_W'(sig_ff);
            mul_b = MUL_B_W'(wet_cap);
         end
         S_MIX3: begin
            mul_a = mix_round[MUL_A_W-1:0];
            mul_b = MUL_B_W'(gain);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // ---- history store access ----
   always_comb begin
      rd_en = 1'b0;
      rd_k  = nst - STG_W'(1);
      if (state_ff == S_SIG && nst != '0) begin
         rd_en = 1'b1;
      end else if (state_ff == S_ST_WB && k_ff != STG_W'(1)) begin
         rd_en = 1'b1;
         rd_k  = k_ff - STG_W'(2);
      end
      rd_addr         = ADDR_W'(int'(p_ff) * MAX_STAGES + int'(rd_k));
      hist_wr.en      = (state_ff == S_ST_WB);
      hist_wr.addr    = ADDR_W'(int'(p_ff) * MAX_STAGES + int'(k_ff) - 1);
      hist_wr.in_val  = sig_ff;
      hist_wr.out_val = sat32(y_full);
   end

   bpp_hist u_hist (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .wr          (hist_wr),
      .rd_in_hist  (rd_in_hist),
      .rd_out_hist (rd_out_hist)
   );

   // ---- configuration registers ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff    <= 1'b0;
         phase_inc_ff <= '0;
         sweep_top_ff <= ONE_Q15;
         sweep_btm_ff <= '0;
         feedback_ff  <= 15'd16384;
         wet_mix_ff   <= 16'd16384;
         stages_ff    <= 4'd12;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BYPASS:    bypass_ff    <= csr_wdata[0];
            CSR_PHASE_INC: phase_inc_ff <= csr_wdata;
            CSR_SWEEP_TOP: sweep_top_ff <= csr_wdata[15:0];
            CSR_SWEEP_BTM: sweep_btm_ff <= csr_wdata[15:0];
            CSR_FEEDBACK:  feedback_ff  <= csr_wdata[14:0];
            CSR_WET_MIX:   wet_mix_ff   <= csr_wdata[15:0];
            CSR_STAGES:    stages_ff    <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lfo_phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
         p_ff         <= '0;
         k_ff         <= '0;
         for (int i = 0; i < PATHS; i++) begin
            fb_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff     <= req_sample_in;
                  p_ff     <= '0;
                  ph_ff    <= lfo_phase_ff;
                  state_ff <= S_DRY;
               end
            end
            S_DRY: begin
               if (bypass_ff) begin
                  out_ff   <= x_ff;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (p_ff == '0) begin
                  dry_ff <= dry_full[STATE_W-1:0];
                  acc_ff <= '0;
               end else begin
                  acc_ff <= acc_next[ACC_W-1:0];
               end
               state_ff <= S_COEF;
            end
            S_COEF: begin
               state_ff <= S_FB;
            end
            S_FB: begin
               coef_ff  <= lo + prod_ff[30:15];
               state_ff <= S_SIG;
            end
            S_SIG: begin
               sig_ff   <= sat32(sig_full);
               k_ff     <= nst;
               state_ff <= (nst == '0) ? S_MIX1 : S_ST_MUL;
            end
            S_ST_MUL: begin
               state_ff <= S_ST_WB;
            end
            S_ST_WB: begin
               sig_ff   <= sat32(y_full);
               k_ff     <= k_ff - STG_W'(1);
               state_ff <= (k_ff == STG_W'(1)) ? S_MIX1 : S_ST_MUL;
            end
            S_MIX1: begin
               fb_ff[p_ff] <= sig_ff;
               state_ff    <= S_MIX2;
            end
            S_MIX2: begin
               tmp_ff   <= prod_ff;
               state_ff <= S_MIX3;
            end
            S_MIX3: begin
               if (p_ff == PATH_W'(PATHS - 1)) begin
                  state_ff <= S_ACC;
               end else begin
                  p_ff     <= p_ff + PATH_W'(1);
                  ph_ff    <= ph_ff + PHASE_STEP;
                  state_ff <= S_SQ;
               end
            end
            S_ACC: begin
               out_ff       <= sat24(out_full);
               lfo_phase_ff <= lfo_phase_ff + phase_inc_ff;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_sample_out_ff <= out_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   // ---- assertions ----
   a_stage_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ST_MUL) |-> (k_ff != '0 && k_ff <= STG_W'(MAX_STAGES)))
      else $error("stage counter out of range during allpass step");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result beat raised outside the output state");

   a_lfo_advance: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && lfo_phase_ff != $past(lfo_phase_ff)) |-> $past(state_ff == S_ACC))
      else $error("LFO phase moved outside the accumulate state");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DRY))
      else $error("accepted beat did not start the sequence");

endmodule

### src/bpp_hist.sv
// ----------------------------------------------------------------------------
// Allpass history store
// Input and output history of every allpass stage of every path, one write
// and one registered read per cycle, with per-entry valid bits so that an
// entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module bpp_hist
   import bpp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   input  bpp_hist_wr_type           wr,
   output logic signed [STATE_W-1:0] rd_in_hist,
   output logic signed [STATE_W-1:0] rd_out_hist
);

   logic signed [STATE_W-1:0] in_mem  [HIST_DEPTH];
   logic signed [STATE_W-1:0] out_mem [HIST_DEPTH];
   logic [HIST_DEPTH-1:0]     valid_ff;
   logic signed [STATE_W-1:0] rd_in_ff;
   logic signed [STATE_W-1:0] rd_out_ff;
   logic                      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         in_mem[wr.addr]  <= wr.in_val;
         out_mem[wr.addr] <= wr.out_val;
      end
      if (rd_en) begin
         rd_in_ff  <= in_mem[rd_addr];
         rd_out_ff <= out_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_in_hist  = rd_valid_ff ? rd_in_ff  : '0;
   assign rd_out_hist = rd_valid_ff ? rd_out_ff : '0;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barberpole phaser testbench
// Streams signed 24-bit samples through the phaser and checks every output
// sample against a cycle-free predictor of the LFO, the allpass chains, the
// feedback and the mix, across a sequence of register settings and idling
// patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import bpp_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES = 150;
   localparam int PHASE_ITEMS = 72;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      bit                         drain_first;
   } sample_beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [2:0]                 csr_index = '0;
   logic [31:0]                csr_wdata = '0;

   sample_beat_type            samples_to_send[$];
   logic signed [SAMPLE_W-1:0] expected_samples[$];

   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   logic hold_kick = 1'b0;
   int cycle_count = 0;
   int beats_in = 0;
   int beats_out = 0;
   int mismatches = 0;
   int settings_loaded = 0;
   int csr_writes = 0;

   bit          cfg_bypass = 1'b0;
   logic [31:0] cfg_phase_inc = '0;
   logic [15:0] cfg_top = 16'd32768;
   logic [15:0] cfg_btm = 16'd0;
   logic [14:0] cfg_feedback = 15'd16384;
   logic [15:0] cfg_wet = 16'd16384;
   logic [3:0]  cfg_stages = 4'd12;

   logic [31:0] lfo_phase = '0;
   int          stage_in_hist[PATHS][MAX_STAGES];
   int          stage_out_hist[PATHS][MAX_STAGES];
   int          path_fb[PATHS];

   barberpole_phaser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint rnd_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   function automatic longint q15_cap(logic [15:0] v);
      longint r;
      r = v;
      return (r > 32768) ? 32768 : r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] phaser_sample(
      logic signed [SAMPLE_W-1:0] smp);
      longint      x, fdb, wet, top, btm, lo, diff, dry, acc;
      longint      mm, gain, sq, coef, y, mixed, res;
      int          sig, nst;
      logic [31:0] ph;
      logic [15:0] m16;
      if (cfg_bypass) return smp;
      x = smp;
      fdb = cfg_feedback;
      wet = q15_cap(cfg_wet);
      top = q15_cap(cfg_top);
      btm = q15_cap(cfg_btm);
      lo = (top < btm) ? top : btm;
      diff = (top < btm) ? btm - top : top - btm;
      nst = (cfg_stages > MAX_STAGES) ? MAX_STAGES : cfg_stages;
      nst = nst & ~1;
      dry = rnd_shift(x * 32 * (131072 - fdb), 17);
      acc = 0;
      for (int p = 0; p < PATHS; p++) begin
         ph = lfo_phase + 32'(p) * PHASE_STEP;
         m16 = ~ph[31:16];
         mm = m16;
         gain = (mm <= 32768) ? mm : 65536 - mm;
         sq = (mm * mm) >>> 17;
         coef = lo + ((sq * diff) >>> 15);
         sig = clamp32(dry + rnd_shift(longint'(path_fb[p]) * fdb, 15));
         for (int k = nst - 1; k >= 0; k--) begin
            y = rnd_shift(coef * (longint'(stage_out_hist[p][k]) + sig), 15)
                - stage_in_hist[p][k];
            stage_in_hist[p][k] = sig;
            stage_out_hist[p][k] = clamp32(y);
            sig = stage_out_hist[p][k];
         end
         path_fb[p] = sig;
         mixed = rnd_shift(dry * (32768 - wet) + longint'(sig) * wet, 15);
         acc += mixed * gain;
      end
      lfo_phase += cfg_phase_inc;
      res = rnd_shift(acc, 21);
      if (res > 8388607) res = 8388607;
      else if (res < -8388608) res = -8388608;
      return res[SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int roll, v;
      roll = $urandom_range(99);
      if (roll < 8) return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      if (roll < 25) begin
         v = int'($urandom_range(512)) - 256;
         return v[SAMPLE_W-1:0];
      end
      return 24'($urandom);
   endfunction

   task automatic flag_mismatch(string what, logic signed [SAMPLE_W-1:0] got,
                                logic signed [SAMPLE_W-1:0] want);
      $display("ERROR %s: got %0d, want %0d, output beat %0d", what, got, want, beats_out);
      mismatches++;
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_BYPASS:    cfg_bypass = value[0];
         CSR_PHASE_INC: cfg_phase_inc = value;
         CSR_SWEEP_TOP: cfg_top = value[15:0];
         CSR_SWEEP_BTM: cfg_btm = value[15:0];
         CSR_FEEDBACK:  cfg_feedback = value[14:0];
         CSR_WET_MIX:   cfg_wet = value[15:0];
         CSR_STAGES:    cfg_stages = value[3:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(bit byp, logic [31:0] inc, logic [31:0] top,
                                logic [31:0] btm, logic [31:0] fb, logic [31:0] wet,
                                logic [31:0] stg);
      write_csr(CSR_BYPASS, {31'b0, byp});
      write_csr(CSR_PHASE_INC, inc);
      write_csr(CSR_SWEEP_TOP, top);
      write_csr(CSR_SWEEP_BTM, btm);
      write_csr(CSR_FEEDBACK, fb);
      write_csr(CSR_WET_MIX, wet);
      write_csr(CSR_STAGES, stg);
      settings_loaded++;
   endtask

   task automatic queue_samples(int count, int drain_at);
      sample_beat_type b;
      for (int i = 0; i < count; i++) begin
         b.sample = pick_sample();
         b.drain_first = (i == drain_at);
         samples_to_send.push_back(b);
      end
   endtask

   task automatic wait_drain();
      while (samples_to_send.size() != 0 || req_valid || expected_samples.size() != 0)
         @(posedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_samples.push_back(phaser_sample(req_sample_in));
            beats_in++;
         end
         if (!req_valid || req_ready) begin
            if (samples_to_send.size() != 0
                && !(samples_to_send[0].drain_first && expected_samples.size() != 0)
                && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_sample_in <= samples_to_send[0].sample;
               void'(samples_to_send.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin : receiver
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               flag_mismatch("unexpected sample_out", rsp_sample_out, 'x);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want)
                  flag_mismatch("sample_out", rsp_sample_out, want);
            end
            beats_out++;
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("barberpole_phaser: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      sample_beat_type            b;
      logic signed [SAMPLE_W-1:0] plain_set[$];
      logic signed [SAMPLE_W-1:0] bypass_set[$];
      plain_set = {24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'sh000001, 24'shFFFFFF,
                   24'sh555555, 24'shAAAAAA, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                   24'sh800000, 24'sh800000, 24'sh800000, 24'sh400000, 24'shC00000,
                   24'sh000000, 24'sh000000};
      bypass_set = {24'sh7FFFFF, 24'sh800000, 24'shFFFFFF, 24'sh003039};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, then bypass
      b.drain_first = 1'b0;
      foreach (plain_set[i]) begin
         b.sample = plain_set[i];
         samples_to_send.push_back(b);
      end
      wait_drain();
      write_csr(CSR_BYPASS, 32'd1);
      foreach (bypass_set[i]) begin
         b.sample = bypass_set[i];
         samples_to_send.push_back(b);
      end
      wait_drain();

      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: load_settings(1'b0, 32'h0100_0000, 32768, 0, 16384, 16384, 12);
            2: load_settings(1'b0, 32'h8000_0000, 65535, 65535, 32767, 65535, 15);
            3: load_settings(1'b0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
            4: load_settings(1'b0, 32'hFFFF_F000, 1000, 30000, 20000, 32768, 2);
            5: load_settings(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(15));
            6: load_settings(1'b0, 32'h0000_0001, 32768, 32768, 32767, 32768, 13);
            7: load_settings(1'b0, $urandom, $urandom_range(32768), $urandom_range(32768),
                             $urandom_range(32767), $urandom_range(32768), 7);
            8: load_settings(1'b0, 32'h0400_0000, 20000, 5000, 8000, 24000, 1);
            default: load_settings(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom_range(15));
         endcase
         case (ph % 4)
            0: begin
               sender_idle_pct <= 0;
               recv_stall_pct <= 0;
            end
            1: begin
               sender_idle_pct <= 72;
               recv_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct <= 0;
               recv_stall_pct <= 72;
            end
            default: begin
               sender_idle_pct <= 15;
               recv_stall_pct <= 15;
            end
         endcase
         if (ph == 4) begin
            // hold the receiver off while the sender keeps offering
            hold_kick <= 1'b1;
            queue_samples(PHASE_ITEMS, -1);
            @(posedge clock);
            hold_kick <= 1'b0;
         end else begin
            queue_samples(PHASE_ITEMS, (ph == 5) ? PHASE_ITEMS / 2 : -1);
         end
         wait_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d samples, checked %0d, over %0d register settings (%0d writes)",
               beats_in, beats_out, settings_loaded, csr_writes);
      $display("covered bypass, capped bounds, odd and oversized stage counts, stalls");
      if (mismatches == 0) begin
         $display("barberpole_phaser: match");
      end else begin
         $display("barberpole_phaser: mismatch");
      end
      $finish;
   end

endmodule
